@@ rtl/core/rvc5_pkg.sv @@
// ----------------------------------------------------------------------------
// rvc5_pkg
// Shared types and constants of the streaming 5x5 RGB convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc5_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int KERNEL_SIZE = 5;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int STORE_ROWS  = KERNEL_SIZE - 1;
   localparam int CHANNELS    = 3;

   localparam int SAMPLE_W  = 8;
   localparam int PIXEL_W   = CHANNELS * SAMPLE_W;
   localparam int COEFF_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int OUT_COL_W = 11;
   localparam int OUT_ROW_W = 12;

   localparam int LINE_WIDTH_W = 12;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int COEFF_PER_WORD = CSR_DATA_W / COEFF_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_FIRST = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_LAST  = 3'd7;

   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd2048;

   // Result words that may be in flight or queued at once.
   localparam int RSP_DEPTH = 8;

   typedef logic [PIXEL_W-1:0]                 pixel_type;
   typedef logic [STORE_ROWS-1:0][PIXEL_W-1:0] column_type;
   typedef logic [TAPS-1:0][PIXEL_W-1:0]       window_type;
   typedef logic [TAPS-1:0][COEFF_W-1:0]       coeff_set_type;

   typedef struct packed {
      logic                 produce;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
   } tag_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  red;
      logic [SAMPLE_W-1:0]  green;
      logic [SAMPLE_W-1:0]  blue;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/core/rvc5_position.sv @@
// ----------------------------------------------------------------------------
// rvc5_position
// Column and row counters of the incoming raster; gives the store address of
// each accepted pixel and its output position.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc5_position #(
   parameter int MAX_WIDTH  = rvc5_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rvc5_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic                                   frame_start,
   input  logic [rvc5_pkg::LINE_WIDTH_W-1:0]      line_width,
   output logic [$clog2(MAX_WIDTH)-1:0]           col,
   output rvc5_pkg::tag_type                      tag
);
   import rvc5_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int EW = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [EW-1:0] lw_ext, width;
   logic [CW-1:0] col_now;
   logic [RW-1:0] row_now;
   logic [EW-1:0] col_next;
   logic [RW:0]   row_next;
   logic [CW-1:0] col_off;
   logic [RW-1:0] row_off;

   always_comb begin
      lw_ext = EW'(line_width);
      if (lw_ext < EW'(KERNEL_SIZE)) begin
         width = EW'(KERNEL_SIZE);
      end else if (lw_ext > EW'(MAX_WIDTH)) begin
         width = EW'(MAX_WIDTH);
      end else begin
         width = lw_ext;
      end

      // A stored column at or past the width (width lowered mid-row) restarts the row at column zero.
      if (frame_start) begin
         col_now = '0;
         row_now = '0;
      end else begin
         col_now = (EW'(col_ff) >= width) ? '0 : col_ff;
         row_now = row_ff;
      end

      col_next = EW'(col_now) + EW'(1);
      row_next = (RW + 1)'(row_now) + (RW + 1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next >= width) begin
            col_in = '0;
            row_in = (row_next >= (RW + 1)'(MAX_HEIGHT)) ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_now;
         end
      end

      col_off = col_now - CW'(KERNEL_SIZE - 1);
      row_off = row_now - RW'(KERNEL_SIZE - 1);
      col         = col_now;
      tag.produce = (col_now >= CW'(KERNEL_SIZE - 1)) && (row_now >= RW'(KERNEL_SIZE - 1));
      tag.col     = OUT_COL_W'(col_off);
      tag.row     = OUT_ROW_W'(row_off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rvc5_line_store.sv @@
// ----------------------------------------------------------------------------
// rvc5_line_store
// Four-row line store, one RAM word per column, and the 5x5 pixel window.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc5_line_store #(
   parameter int MAX_WIDTH = rvc5_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [$clog2(MAX_WIDTH)-1:0]   in_col,
   input  rvc5_pkg::pixel_type            in_pixel,
   input  rvc5_pkg::tag_type              in_tag,
   output logic                           win_valid,
   output rvc5_pkg::tag_type              win_tag,
   output rvc5_pkg::window_type           win_pixels
);
   import rvc5_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   column_type    store_ram [MAX_WIDTH];
   column_type    rd_data_ff;

   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_col_ff;
   pixel_type     s1_pixel_ff;
   tag_type       s1_tag_ff;

   logic          wr_valid_ff, wr_valid_in;
   logic [CW-1:0] wr_col_ff;
   column_type    wr_data_ff;

   window_type    window_ff, window_in;
   logic          win_valid_ff, win_valid_in;
   tag_type       win_tag_ff;

   column_type    old_col, new_col;

   assign s1_valid_in  = in_valid;
   assign wr_valid_in  = s1_valid_ff;
   assign win_valid_in = s1_valid_ff;

   always_comb begin
      // The word written at the edge that read this column is still in flight.
      if (wr_valid_ff && (wr_col_ff == s1_col_ff)) begin
         old_col = wr_data_ff;
      end else begin
         old_col = rd_data_ff;
      end

      for (int r = 0; r < STORE_ROWS - 1; r++) begin
         new_col[r] = old_col[r+1];
      end
      new_col[STORE_ROWS-1] = s1_pixel_ff;

      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
               window_in[r*KERNEL_SIZE+c] = window_ff[r*KERNEL_SIZE+c+1];
            end
         end
         for (int r = 0; r < STORE_ROWS; r++) begin
            window_in[r*KERNEL_SIZE+KERNEL_SIZE-1] = old_col[r];
         end
         window_in[TAPS-1] = s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rd_data_ff <= store_ram[in_col];
      end
      if (s1_valid_ff) begin
         store_ram[s1_col_ff] <= new_col;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff   <= in_col;
      s1_pixel_ff <= in_pixel;
      s1_tag_ff   <= in_tag;
      wr_col_ff   <= s1_col_ff;
      wr_data_ff  <= new_col;
      window_ff   <= window_in;
      win_tag_ff  <= s1_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         win_valid_ff <= win_valid_in;
      end
   end

   assign win_valid  = win_valid_ff;
   assign win_tag    = win_tag_ff;
   assign win_pixels = window_ff;

endmodule

`default_nettype wire

@@ rtl/core/rvc5_mac.sv @@
// ----------------------------------------------------------------------------
// rvc5_mac
// Multiply-accumulate of the window: registered products, registered row
// sums, then the total with truncation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc5_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      win_valid,
   input  rvc5_pkg::tag_type         win_tag,
   input  rvc5_pkg::window_type      win_pixels,
   input  rvc5_pkg::coeff_set_type   coeffs,
   output logic                      res_valid,
   output rvc5_pkg::rsp_word_type    res_word
);
   import rvc5_pkg::*;

   localparam int PROD_W = COEFF_W + SAMPLE_W;
   localparam int ROW_W  = PROD_W + $clog2(KERNEL_SIZE);
   localparam int SUM_W  = ROW_W + $clog2(KERNEL_SIZE);
   localparam int SHR_W  = SUM_W - FRAC_W;

   logic [PROD_W-1:0] prod_ff   [CHANNELS][TAPS];
   logic [PROD_W-1:0] prod_in   [CHANNELS][TAPS];
   logic [ROW_W-1:0]  rowsum_ff [CHANNELS][KERNEL_SIZE];
   logic [ROW_W-1:0]  rowsum_in [CHANNELS][KERNEL_SIZE];
   logic [SUM_W-1:0]  total     [CHANNELS];
   logic [SHR_W-1:0]  shifted   [CHANNELS];
   logic [SAMPLE_W-1:0] chan_in [CHANNELS];

   logic         prod_valid_ff, prod_valid_in;
   logic         row_valid_ff, row_valid_in;
   logic         res_valid_ff, res_valid_in;
   tag_type      prod_tag_ff, row_tag_ff;
   rsp_word_type res_word_ff, res_word_in;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int t = 0; t < TAPS; t++) begin
            prod_in[ch][t] = PROD_W'(coeffs[t])
                           * PROD_W'(win_pixels[t][ch*SAMPLE_W +: SAMPLE_W]);
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            rowsum_in[ch][r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               rowsum_in[ch][r] = rowsum_in[ch][r]
                                + ROW_W'(prod_ff[ch][r*KERNEL_SIZE+c]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         total[ch] = '0;
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            total[ch] = total[ch] + SUM_W'(rowsum_ff[ch][r]);
         end
         shifted[ch] = total[ch][SUM_W-1:FRAC_W];
         if (shifted[ch] > SHR_W'({SAMPLE_W{1'b1}})) begin
            chan_in[ch] = {SAMPLE_W{1'b1}};
         end else begin
            chan_in[ch] = shifted[ch][SAMPLE_W-1:0];
         end
      end
      res_word_in.red   = chan_in[0];
      res_word_in.green = chan_in[1];
      res_word_in.blue  = chan_in[2];
      res_word_in.col   = row_tag_ff.col;
      res_word_in.row   = row_tag_ff.row;
   end

   // Only windows that complete a full 5x5 area carry a result onward.
   assign prod_valid_in = win_valid && win_tag.produce;
   assign row_valid_in  = prod_valid_ff;
   assign res_valid_in  = row_valid_ff;

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      rowsum_ff   <= rowsum_in;
      prod_tag_ff <= win_tag;
      row_tag_ff  <= prod_tag_ff;
      res_word_ff <= res_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         row_valid_ff  <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         row_valid_ff  <= row_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_word  = res_word_ff;

endmodule

`default_nettype wire

@@ rtl/core/rvc5_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// rvc5_rsp_fifo
// Small result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc5_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rvc5_pkg::rsp_word_type    push_word,
   input  logic                      pop,
   output logic                      not_empty,
   output rvc5_pkg::rsp_word_type    head_word
);
   import rvc5_pkg::*;

   localparam int PW = $clog2(RSP_DEPTH);

   rsp_word_type  entry_ff [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW + 1)'(push) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/core/rgb_valid_convolution_5x5_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_valid_convolution_5x5_unit
// Streaming 5x5 valid convolution of an RGB raster with one shared kernel of
// unsigned Q0.16 coefficients; one filtered pixel per position where a full
// 5x5 area is available.
//
//   Port group   Direction   Handshake            Word
//   req_*        in          req_valid/req_stall  one pixel, frame start flag
//   rsp_*        out         rsp_valid/rsp_stall  filtered pixel, column, row
//   csr_*        in          csr_wen              register index and data
//
// One pixel is accepted every cycle while req_stall is low; a result is offered
// once its pixel has passed the line store input register, the window register,
// three MAC stages and the write into the result queue.
// Up to eight results may be counted between acceptance and delivery, in the
// pipeline or in the queue; req_stall rises at that count, which only a held
// rsp_stall can bring about.
// Reset is synchronous; it clears counters and valid state. The
// line store and window are not cleared and hold data only once written.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_valid_convolution_5x5_unit #(
   parameter int MAX_WIDTH  = rvc5_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rvc5_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rvc5_pkg::SAMPLE_W-1:0]       req_in_red,
   input  logic [rvc5_pkg::SAMPLE_W-1:0]       req_in_green,
   input  logic [rvc5_pkg::SAMPLE_W-1:0]       req_in_blue,
   input  logic                                req_frame_start,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rvc5_pkg::SAMPLE_W-1:0]       rsp_out_red,
   output logic [rvc5_pkg::SAMPLE_W-1:0]       rsp_out_green,
   output logic [rvc5_pkg::SAMPLE_W-1:0]       rsp_out_blue,
   output logic [rvc5_pkg::OUT_COL_W-1:0]      rsp_out_col,
   output logic [rvc5_pkg::OUT_ROW_W-1:0]      rsp_out_row,

   input  logic                                csr_wen,
   input  logic [rvc5_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rvc5_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rvc5_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int OW = $clog2(RSP_DEPTH + 1);

   logic [LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   coeff_set_type           coeff_ff, coeff_in;

   logic [OW-1:0] outstanding_ff, outstanding_in;

   logic          req_accept, rsp_accept;
   logic [CW-1:0] pos_col;
   tag_type       pos_tag;
   pixel_type     req_pixel;

   logic          win_valid;
   tag_type       win_tag;
   window_type    win_pixels;

   logic          res_valid;
   rsp_word_type  res_word;
   rsp_word_type  head_word;

   // Configuration registers.
   always_comb begin
      line_width_in = line_width_ff;
      coeff_in      = coeff_ff;
      if (csr_wen && (csr_index == CSR_LINE_WIDTH)) begin
         line_width_in = csr_wdata[LINE_WIDTH_W-1:0];
      end
      for (int t = 0; t < TAPS; t++) begin
         if (csr_wen && (csr_index == CSR_COEFF_FIRST + CSR_INDEX_W'(t / COEFF_PER_WORD))) begin
            coeff_in[t] = csr_wdata[(t % COEFF_PER_WORD)*COEFF_W +: COEFF_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         coeff_ff      <= '0;
      end else begin
         line_width_ff <= line_width_in;
         coeff_ff      <= coeff_in;
      end
   end

   // Credit count: results accepted for production but not yet delivered.
   assign req_stall  = (outstanding_ff >= OW'(RSP_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign outstanding_in = outstanding_ff + OW'(req_accept && pos_tag.produce)
                         - OW'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   assign req_pixel = {req_in_blue, req_in_green, req_in_red};

   rvc5_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .frame_start (req_frame_start),
      .line_width  (line_width_ff),
      .col         (pos_col),
      .tag         (pos_tag)
   );

   rvc5_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_col     (pos_col),
      .in_pixel   (req_pixel),
      .in_tag     (pos_tag),
      .win_valid  (win_valid),
      .win_tag    (win_tag),
      .win_pixels (win_pixels)
   );

   rvc5_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .win_valid  (win_valid),
      .win_tag    (win_tag),
      .win_pixels (win_pixels),
      .coeffs     (coeff_ff),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   rvc5_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .pop       (rsp_accept),
      .not_empty (rsp_valid),
      .head_word (head_word)
   );

   assign rsp_out_red   = head_word.red;
   assign rsp_out_green = head_word.green;
   assign rsp_out_blue  = head_word.blue;
   assign rsp_out_col   = head_word.col;
   assign rsp_out_row   = head_word.row;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OW'(RSP_DEPTH))
      else $error("outstanding result count exceeds the queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result word offered without an outstanding credit");

   a_res_has_credit: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (outstanding_ff != '0))
      else $error("pipeline produced a result that was never counted");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");
`endif

endmodule

`default_nettype wire
